[hw/rtl/chm_pkg.sv]
package chm_pkg;

   // Field widths of the item streams
   localparam int OP_W  = 2;
   localparam int KEY_W = 16;
   localparam int VAL_W = 32;
   localparam int ST_W  = 2;

   // Operation codes
   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

   // Result status codes
   localparam logic [ST_W-1:0] ST_OK      = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
   localparam logic [ST_W-1:0] ST_MISSING = 2'd2;

   typedef struct packed {
      logic [ST_W-1:0]  status;
      logic [VAL_W-1:0] found_value;
   } chm_result_type;

endpackage

[hw/rtl/chm_hash.sv]
module chm_hash #(
   parameter int TABLE_SIZE = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [chm_pkg::KEY_W-1:0]     key,
   output logic                          done,
   output logic [$clog2(TABLE_SIZE)-1:0] rem
);

   localparam int KW = chm_pkg::KEY_W;
   localparam int IW = $clog2(TABLE_SIZE);
   localparam int SH = KW + IW;
   localparam int MW = KW + 1;
   localparam int PW = KW + MW;
   localparam longint unsigned RECIP =
      ((64'd1 << SH) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
   localparam logic [MW-1:0] RECIP_M = MW'(RECIP);
   localparam logic [KW-1:0] TS_K = KW'(TABLE_SIZE);

   logic [KW-1:0] key_ff;
   logic [KW-1:0] quo_ff;
   logic [KW-1:0] quo_in;
   logic          done_ff;
   logic [PW-1:0] prod;
   logic [KW-1:0] back;
   logic [KW-1:0] diff;

   // Quotient by rounded-up reciprocal multiply, exact over the whole key range
   always_comb begin
      prod   = PW'(key) * PW'(RECIP_M);
      quo_in = KW'(prod >> SH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
      end
   end

   // Hold the key and its quotient for the remainder step
   always_ff @(posedge clock) begin
      if (start) begin
         key_ff <= key;
         quo_ff <= quo_in;
      end
   end

   // Subtract quotient times table size to get the home slot
   assign back = KW'(quo_ff * TS_K);
   assign diff = key_ff - back;

   assign done = done_ff;
   assign rem  = diff[IW-1:0];

endmodule

[hw/rtl/chm_ctrl.sv]
module chm_ctrl #(
   parameter int TABLE_SIZE = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [chm_pkg::OP_W-1:0]       in_op,
   input  logic [chm_pkg::KEY_W-1:0]      in_key,
   input  logic [chm_pkg::VAL_W-1:0]      in_val,
   output logic                           res_valid,
   input  logic                           res_ready,
   output chm_pkg::chm_result_type        res
);

   localparam int IW = $clog2(TABLE_SIZE);
   localparam int LW = IW + 1;
   localparam logic [LW-1:0] NONE = '1;
   localparam logic [LW-1:0] TS_L = LW'(TABLE_SIZE);
   localparam logic [IW-1:0] LAST = IW'(TABLE_SIZE - 1);

   localparam logic [4:0] S_CLEAR = 5'd0;
   localparam logic [4:0] S_IDLE  = 5'd1;
   localparam logic [4:0] S_HASH  = 5'd2;
   localparam logic [4:0] S_FND   = 5'd3;
   localparam logic [4:0] S_ADD   = 5'd4;
   localparam logic [4:0] S_SKIP  = 5'd5;
   localparam logic [4:0] S_SKIPW = 5'd6;
   localparam logic [4:0] S_WALK  = 5'd7;
   localparam logic [4:0] S_WALKW = 5'd8;
   localparam logic [4:0] S_APP1  = 5'd9;
   localparam logic [4:0] S_APP2  = 5'd10;
   localparam logic [4:0] S_SCAN  = 5'd11;
   localparam logic [4:0] S_SCANW = 5'd12;
   localparam logic [4:0] S_RMCHK = 5'd13;
   localparam logic [4:0] S_MVCHK = 5'd14;
   localparam logic [4:0] S_MVW   = 5'd15;
   localparam logic [4:0] S_FINRD = 5'd16;
   localparam logic [4:0] S_FINW  = 5'd17;
   localparam logic [4:0] S_FREE  = 5'd18;
   localparam logic [4:0] S_DONE  = 5'd19;

   typedef struct packed {
      logic                      used;
      logic [LW-1:0]             link;
      logic [IW-1:0]             home;
      logic [chm_pkg::KEY_W-1:0] key;
      logic [chm_pkg::VAL_W-1:0] value;
   } entry_type;

   // Slot table: one write and one registered read per cycle
   entry_type mem [TABLE_SIZE];
   entry_type mem_q_ff;
   logic      mem_we;
   logic [IW-1:0] waddr;
   logic [IW-1:0] raddr;
   entry_type wdata;

   logic [4:0] state_ff, state_in;
   logic [chm_pkg::OP_W-1:0]  op_ff, op_in;
   logic [chm_pkg::KEY_W-1:0] key_ff, key_in;
   logic [chm_pkg::VAL_W-1:0] val_ff, val_in;
   logic [IW-1:0] home_ff, home_in;
   logic [IW-1:0] clr_ff, clr_in;
   logic [LW-1:0] cur_ff, cur_in;
   entry_type     cur_e_ff, cur_e_in;
   logic [LW-1:0] j_ff, j_in;
   logic [LW-1:0] p_ff, p_in;
   logic [LW-1:0] pp_ff, pp_in;
   logic [LW-1:0] idx_ff, idx_in;
   logic [LW-1:0] ff_ff, ff_in;
   logic          phase_ff, phase_in;
   chm_pkg::chm_result_type res_ff, res_in;

   logic          hash_start;
   logic          hash_done;
   logic [IW-1:0] hash_rem;

   chm_hash #(.TABLE_SIZE(TABLE_SIZE)) u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (in_key),
      .done  (hash_done),
      .rem   (hash_rem)
   );

   assign in_ready   = (state_ff == S_IDLE);
   assign hash_start = in_valid && in_ready;
   assign res_valid  = (state_ff == S_DONE);
   assign res        = res_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      mem_q_ff <= mem[raddr];
   end

   // Sequence one operation through the slot table
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      key_in   = key_ff;
      val_in   = val_ff;
      home_in  = home_ff;
      clr_in   = clr_ff;
      cur_in   = cur_ff;
      cur_e_in = cur_e_ff;
      j_in     = j_ff;
      p_in     = p_ff;
      pp_in    = pp_ff;
      idx_in   = idx_ff;
      ff_in    = ff_ff;
      phase_in = phase_ff;
      res_in   = res_ff;
      mem_we   = 1'b0;
      waddr    = cur_ff[IW-1:0];
      raddr    = cur_ff[IW-1:0];
      wdata    = cur_e_ff;

      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            waddr  = clr_ff;
            wdata  = '{used: 1'b0, link: NONE, home: '0, key: '0, value: '0};
            if (clr_ff == LAST) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (in_valid) begin
               op_in    = in_op;
               key_in   = in_key;
               val_in   = in_val;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (hash_done) begin
               home_in = hash_rem;
               cur_in  = {1'b0, hash_rem};
               raddr   = hash_rem;
               res_in  = '{status: chm_pkg::ST_OK, found_value: '0};
               case (op_ff)
                  chm_pkg::OP_ADD:    state_in = S_ADD;
                  chm_pkg::OP_SEARCH: state_in = S_FND;
                  chm_pkg::OP_REMOVE: begin
                     idx_in   = '0;
                     j_in     = NONE;
                     state_in = S_SCAN;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         // Follow the chain until the key turns up or the chain ends
         S_FND: begin
            if (mem_q_ff.used && mem_q_ff.key == key_ff) begin
               res_in.found_value = mem_q_ff.value;
               state_in = S_DONE;
            end else if (mem_q_ff.link[LW-1]) begin
               res_in.status = chm_pkg::ST_MISSING;
               state_in = S_DONE;
            end else begin
               cur_in = mem_q_ff.link;
               raddr  = mem_q_ff.link[IW-1:0];
            end
         end
         S_ADD: begin
            if (!mem_q_ff.used) begin
               mem_we   = 1'b1;
               waddr    = home_ff;
               wdata    = '{used: 1'b1, link: NONE, home: home_ff, key: key_ff,
                            value: val_ff};
               state_in = S_DONE;
            end else begin
               cur_e_in = mem_q_ff;
               phase_in = 1'b0;
               state_in = S_SKIP;
            end
         end
         // Advance first-free past used slots; running off the table before appending reports full
         S_SKIP: begin
            raddr = ff_ff[IW-1:0];
            if (ff_ff < TS_L) begin
               state_in = S_SKIPW;
            end else begin
               if (!phase_ff) begin
                  res_in.status = chm_pkg::ST_FULL;
               end
               state_in = S_DONE;
            end
         end
         S_SKIPW: begin
            if (mem_q_ff.used) begin
               ff_in    = ff_ff + 1'b1;
               state_in = S_SKIP;
            end else if (phase_ff) begin
               state_in = S_DONE;
            end else begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            raddr = cur_e_ff.link[IW-1:0];
            if (cur_e_ff.link[LW-1]) begin
               state_in = S_APP1;
            end else begin
               cur_in   = cur_e_ff.link;
               state_in = S_WALKW;
            end
         end
         S_WALKW: begin
            cur_e_in = mem_q_ff;
            state_in = S_WALK;
         end
         S_APP1: begin
            mem_we   = 1'b1;
            waddr    = ff_ff[IW-1:0];
            wdata    = '{used: 1'b1, link: NONE, home: home_ff, key: key_ff,
                         value: val_ff};
            state_in = S_APP2;
         end
         S_APP2: begin
            mem_we     = 1'b1;
            wdata      = cur_e_ff;
            wdata.link = ff_ff;
            ff_in      = ff_ff + 1'b1;
            phase_in   = 1'b1;
            state_in   = S_SKIP;
         end
         // Find the slot that links to the home slot
         S_SCAN: begin
            raddr    = idx_ff[IW-1:0];
            state_in = S_SCANW;
         end
         S_SCANW: begin
            raddr = home_ff;
            if (mem_q_ff.link == {1'b0, home_ff}) begin
               j_in     = idx_ff;
               state_in = S_RMCHK;
            end else if (idx_ff[IW-1:0] == LAST) begin
               state_in = S_RMCHK;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SCAN;
            end
         end
         S_RMCHK: begin
            raddr = mem_q_ff.link[IW-1:0];
            if (mem_q_ff.used && mem_q_ff.key == key_ff) begin
               cur_e_in = mem_q_ff;
               p_in     = mem_q_ff.link;
               pp_in    = cur_ff;
               state_in = S_MVCHK;
            end else if (mem_q_ff.link[LW-1]) begin
               res_in.status = chm_pkg::ST_MISSING;
               state_in = S_DONE;
            end else begin
               j_in   = cur_ff;
               cur_in = mem_q_ff.link;
            end
         end
         // Pull forward a later member whose home is the vacated slot
         S_MVCHK: begin
            raddr = p_ff[IW-1:0];
            if (p_ff[LW-1]) begin
               state_in = S_FINRD;
            end else begin
               state_in = S_MVW;
            end
         end
         S_MVW: begin
            if (mem_q_ff.used && mem_q_ff.home == cur_ff[IW-1:0]) begin
               mem_we     = 1'b1;
               wdata      = cur_e_ff;
               wdata.home = mem_q_ff.home;
               wdata.key  = mem_q_ff.key;
               wdata.value = mem_q_ff.value;
               j_in       = pp_ff;
               cur_in     = p_ff;
               cur_e_in   = mem_q_ff;
               pp_in      = p_ff;
            end else begin
               pp_in = p_ff;
            end
            p_in     = mem_q_ff.link;
            state_in = S_MVCHK;
         end
         S_FINRD: begin
            raddr = j_ff[IW-1:0];
            if (j_ff[LW-1]) begin
               state_in = S_FREE;
            end else begin
               state_in = S_FINW;
            end
         end
         S_FINW: begin
            mem_we     = 1'b1;
            waddr      = j_ff[IW-1:0];
            wdata      = mem_q_ff;
            wdata.link = cur_e_ff.link;
            state_in   = S_FREE;
         end
         S_FREE: begin
            mem_we = 1'b1;
            wdata  = '{used: 1'b0, link: NONE, home: '0, key: '0, value: '0};
            if (ff_ff > cur_ff) begin
               ff_in = cur_ff;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         ff_ff    <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         ff_ff    <= ff_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      key_ff   <= key_in;
      val_ff   <= val_in;
      home_ff  <= home_in;
      cur_ff   <= cur_in;
      cur_e_ff <= cur_e_in;
      j_ff     <= j_in;
      p_ff     <= p_in;
      pp_ff    <= pp_in;
      idx_ff   <= idx_in;
      phase_ff <= phase_in;
      res_ff   <= res_in;
   end

   a_ff_range: assert property (@(posedge clock) disable iff (reset)
      ff_ff <= TS_L) else $error("first-free beyond table");

   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ({1'b0, waddr} < TS_L)) else $error("write outside table");

   a_accept_hash: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> (state_ff == S_HASH)) else $error("accept lost");

   a_res_hold: assert property (@(posedge clock) disable iff (reset)
      (res_valid && !res_ready) |=> (res_valid && $stable(res_ff)))
      else $error("result dropped while stalled");

endmodule

[hw/rtl/coalesced_hash_map_top.sv]
// Steps: key modulo by reciprocal multiply, the table walk, then the result handoff:
//   search follows the chain slot by slot; add writes a free home slot, else advances
//   first-free past used slots, walks the chain and appends; remove scans for the
//   predecessor, walks the chain, checks later members for pull-forward, then frees.
// Throughput: one item at a time; the next is accepted once the result is handed off.
// Reset: synchronous; a clearing pass over all TABLE_SIZE slots then runs with req_tready low.
module coalesced_hash_map_top #(
   parameter int TABLE_SIZE = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // key [15:0], value [47:16]
   input  logic [1:0]  req_tuser,   // opcode [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // found_value [31:0]
   output logic [1:0]  rsp_tuser    // status [1:0]
);

   logic                    res_valid;
   logic                    res_ready;
   chm_pkg::chm_result_type res;
   logic                    rsp_valid_ff;
   chm_pkg::chm_result_type rsp_ff;

   chm_ctrl #(.TABLE_SIZE(TABLE_SIZE)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_op     (req_tuser),
      .in_key    (req_tdata[15:0]),
      .in_val    (req_tdata[47:16]),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // Hold the result so the sequencer can move on to the next item
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.found_value;
   assign rsp_tuser  = rsp_ff.status;

endmodule

[tb/coalesced_hash_map_top_tb.sv]
`timescale 1ns / 1ps

module coalesced_hash_map_top_tb;

   localparam int SLOTS = 16;
   localparam int NO_LINK = -1;
   localparam logic [chm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 900000;
   localparam int RANDOM_ITEMS = 700;
   localparam int QUIET_ITEMS = 100;

   // Mirror of the slot table; predicts one result per operation
   class hash_map_scoreboard;
      logic [chm_pkg::KEY_W-1:0] slot_key[SLOTS];
      logic [chm_pkg::VAL_W-1:0] slot_val[SLOTS];
      int                        slot_next[SLOTS];
      bit                        slot_full[SLOTS];
      int                        free_ptr;
      chm_pkg::chm_result_type   expected_q[$];
      int                        errors;

      function new();
         for (int s = 0; s < SLOTS; s++) begin
            slot_key[s] = '0;
            slot_val[s] = '0;
            slot_next[s] = NO_LINK;
            slot_full[s] = 0;
         end
         free_ptr = 0;
         errors = 0;
      endfunction

      function int home(logic [chm_pkg::KEY_W-1:0] k);
         return int'(k) % SLOTS;
      endfunction

      function int next_of(int s);
         if (s < 0 || s >= SLOTS) return NO_LINK;
         return (slot_next[s] >= 0 && slot_next[s] < SLOTS) ? slot_next[s] : NO_LINK;
      endfunction

      function bit holds(int s, logic [chm_pkg::KEY_W-1:0] k);
         return s >= 0 && s < SLOTS && slot_full[s] && slot_key[s] == k;
      endfunction

      function int locate(logic [chm_pkg::KEY_W-1:0] k);
         int s;
         int steps;
         s = home(k);
         steps = 0;
         while (s != NO_LINK && !holds(s, k)) begin
            steps++;
            if (steps > SLOTS) return NO_LINK;
            s = next_of(s);
         end
         return s;
      endfunction

      function void skip_full();
         while (free_ptr < SLOTS && slot_full[free_ptr]) free_ptr++;
      endfunction

      function void store(int s, logic [chm_pkg::KEY_W-1:0] k,
                          logic [chm_pkg::VAL_W-1:0] v);
         slot_key[s] = k;
         slot_val[s] = v;
         slot_next[s] = NO_LINK;
         slot_full[s] = 1;
      endfunction

      function logic [chm_pkg::ST_W-1:0] insert(logic [chm_pkg::KEY_W-1:0] k,
                                                logic [chm_pkg::VAL_W-1:0] v);
         int pos;
         int tail;
         int nx;
         int steps;
         pos = home(k);
         if (!slot_full[pos]) begin
            store(pos, k, v);
            return chm_pkg::ST_OK;
         end
         skip_full();
         if (free_ptr >= SLOTS) return chm_pkg::ST_FULL;
         // walk to the chain tail, then append at the free slot
         tail = pos;
         steps = 0;
         nx = next_of(tail);
         while (nx != NO_LINK && steps < SLOTS) begin
            tail = nx;
            nx = next_of(tail);
            steps++;
         end
         store(free_ptr, k, v);
         slot_next[tail] = free_ptr;
         free_ptr++;
         skip_full();
         return chm_pkg::ST_OK;
      endfunction

      function logic [chm_pkg::ST_W-1:0] delete(logic [chm_pkg::KEY_W-1:0] k);
         int i;
         int j;
         int p;
         int pp;
         int walk;
         int steps;
         int rounds;
         i = home(k);
         j = NO_LINK;
         steps = 0;
         rounds = 0;
         // find a slot that links into the home slot
         for (int idx = 0; idx < SLOTS; idx++) begin
            if (next_of(idx) == i) begin
               j = idx;
               break;
            end
         end
         while (i != NO_LINK && !holds(i, k)) begin
            steps++;
            if (steps > SLOTS) return chm_pkg::ST_MISSING;
            j = i;
            i = next_of(i);
         end
         if (i == NO_LINK) return chm_pkg::ST_MISSING;
         // pull forward later members whose home is the vacated slot
         forever begin
            p = next_of(i);
            pp = i;
            walk = 0;
            while (p != NO_LINK && walk < SLOTS &&
                   !(slot_full[p] && home(slot_key[p]) == i)) begin
               pp = p;
               p = next_of(p);
               walk++;
            end
            if (p == NO_LINK || walk >= SLOTS) break;
            rounds++;
            if (rounds > SLOTS) break;
            slot_key[i] = slot_key[p];
            slot_val[i] = slot_val[p];
            j = pp;
            i = p;
         end
         if (j != NO_LINK) slot_next[j] = slot_next[i];
         slot_key[i] = '0;
         slot_val[i] = '0;
         slot_next[i] = NO_LINK;
         slot_full[i] = 0;
         if (free_ptr > i) free_ptr = i;
         return chm_pkg::ST_OK;
      endfunction

      function void note_item(logic [chm_pkg::OP_W-1:0] op, logic [chm_pkg::KEY_W-1:0] k,
                              logic [chm_pkg::VAL_W-1:0] v);
         chm_pkg::chm_result_type r;
         int s;
         r.status = chm_pkg::ST_OK;
         r.found_value = '0;
         case (op)
            chm_pkg::OP_ADD: begin
               r.status = insert(k, v);
            end
            chm_pkg::OP_REMOVE: begin
               r.status = delete(k);
            end
            chm_pkg::OP_SEARCH: begin
               s = locate(k);
               if (s == NO_LINK) r.status = chm_pkg::ST_MISSING;
               else r.found_value = slot_val[s];
            end
            default: ;
         endcase
         expected_q.push_back(r);
      endfunction

      function void check_result(logic [chm_pkg::ST_W-1:0] st,
                                 logic [chm_pkg::VAL_W-1:0] fv);
         chm_pkg::chm_result_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result status %0d value %h", $time, st, fv);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (st !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, st);
            errors++;
         end
         if (fv !== e.found_value) begin
            $display("%0t: found_value expected %h actual %h", $time, e.found_value, fv);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [47:0]       req_tdata;   // key [15:0], value [47:16]
   logic [1:0]        req_tuser;   // opcode [1:0]
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [31:0]       rsp_tdata;   // found_value [31:0]
   logic [1:0]        rsp_tuser;   // status [1:0]

   hash_map_scoreboard sb = new();
   bit                 quiet = 0;
   bit                 hold_request = 0;
   int                 cycles = 0;

   coalesced_hash_map_top #(.TABLE_SIZE(SLOTS)) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("coalesced_hash_map_top verification failed");
         $finish;
      end
   end

   // Check every accepted result
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tuser, rsp_tdata);
   end

   // Receiver: random stalls, one long hold-off on request
   initial begin
      rsp_tready <= 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_tready <= 0;
            repeat (400) @(posedge clock);
            hold_request = 0;
         end else if (quiet || $urandom_range(0, 3) != 0) begin
            rsp_tready <= 1;
            @(posedge clock);
         end else begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
      end
   end

   // Offer one item and hold it until accepted
   task automatic send_item(logic [chm_pkg::OP_W-1:0] op, logic [chm_pkg::KEY_W-1:0] k,
                            logic [chm_pkg::VAL_W-1:0] v);
      req_tvalid <= 1;
      req_tuser <= op;
      req_tdata <= {v, k};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_item(op, k, v);
   endtask

   // Insert a random idle burst now and then
   task automatic maybe_idle();
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [chm_pkg::OP_W-1:0] pick_op(int add_weight);
      int r;
      r = $urandom_range(0, 99);
      if (r < add_weight) return chm_pkg::OP_ADD;
      if (r < add_weight + (95 - add_weight) / 2) return chm_pkg::OP_REMOVE;
      if (r < 95) return chm_pkg::OP_SEARCH;
      return OP_UNUSED;
   endfunction

   function automatic logic [chm_pkg::KEY_W-1:0] pick_key(int homes);
      // mostly a small pool of colliding keys, sometimes anything
      if ($urandom_range(0, 6) == 0) return chm_pkg::KEY_W'($urandom);
      return chm_pkg::KEY_W'($urandom_range(0, homes - 1) + SLOTS * $urandom_range(0, 3));
   endfunction

   initial begin
      int add_weight;
      int homes;
      reset <= 1;
      req_tvalid <= 0;
      req_tdata <= '0;
      req_tuser <= chm_pkg::OP_ADD;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: extremes, collisions, pull-forward, misses, unused opcode
      send_item(chm_pkg::OP_ADD, 16'd0, 32'h7fffffff);
      send_item(chm_pkg::OP_ADD, 16'hffff, 32'h80000000);
      send_item(chm_pkg::OP_ADD, 16'd16, 32'h00000001);
      send_item(chm_pkg::OP_ADD, 16'd32, 32'hffffffff);
      send_item(chm_pkg::OP_ADD, 16'd16, 32'h12345678);
      send_item(chm_pkg::OP_SEARCH, 16'd16, 32'hdeadbeef);
      send_item(chm_pkg::OP_SEARCH, 16'd48, 32'h0);
      send_item(chm_pkg::OP_REMOVE, 16'd0, 32'h55555555);
      send_item(chm_pkg::OP_SEARCH, 16'd16, 32'h0);
      send_item(chm_pkg::OP_SEARCH, 16'd32, 32'h0);
      send_item(chm_pkg::OP_REMOVE, 16'd48, 32'h0);
      send_item(OP_UNUSED, 16'hffff, 32'hffffffff);
      for (int n = 0; n < 12; n++) begin
         send_item(chm_pkg::OP_ADD, chm_pkg::KEY_W'(n * SLOTS + 5), 32'(n));
      end
      send_item(chm_pkg::OP_ADD, 16'd5, 32'haaaaaaaa);
      send_item(chm_pkg::OP_SEARCH, 16'hffff, 32'h0);
      drain();

      // Random: phases that fill and empty the table
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) begin
            add_weight = (n / 100) % 2 == 0 ? 60 : 25;
            homes = $urandom_range(1, SLOTS);
         end
         if (n == 250) hold_request = 1;
         if (n == 450) drain();
         if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1;
         send_item(pick_op(add_weight), pick_key(homes), chm_pkg::VAL_W'($urandom));
         maybe_idle();
      end
      req_tvalid <= 0;

      // Wait out remaining results, then a tail for stray ones
      while (sb.pending() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("coalesced_hash_map_top verification clean");
      end else begin
         $display("coalesced_hash_map_top verification failed");
      end
      $finish;
   end

endmodule
